>>> design/bced_pkg.sv
// Types and codes shared by the button click event detector.
package bced_pkg;

   typedef enum logic [1:0] {
      ST_STANDBY  = 2'd0,
      ST_DEBOUNCE = 2'd1,
      ST_ACTIVE   = 2'd2,
      ST_POST     = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      EV_NONE   = 4'd0,
      EV_DOWN   = 4'd1,
      EV_HOLD   = 4'd2,
      EV_UP     = 4'd3,
      EV_CLICK  = 4'd4,
      EV_LONG   = 4'd5,
      EV_DOUBLE = 4'd6,
      EV_TRIPLE = 4'd7,
      EV_MULTI  = 4'd8
   } event_type;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DEBOUNCE     = 3'd0,
      CSR_HOLDDOWN     = 3'd1,
      CSR_LONG_CLICK   = 3'd2,
      CSR_DOUBLE_CLICK = 3'd3,
      CSR_FILTER_MULTI = 3'd4,
      CSR_ENABLE       = 3'd5
   } csr_index_type;

   localparam logic [15:0] DebounceReset    = 16'd20;
   localparam logic [15:0] HolddownReset    = 16'd1000;
   localparam logic [15:0] LongClickReset   = 16'd3000;
   localparam logic [15:0] DoubleClickReset = 16'd250;
   localparam logic [7:0]  ClickMax         = 8'd255;
   localparam logic [7:0]  ClickOne         = 8'd1;
   localparam logic [7:0]  ClickTwo         = 8'd2;
   localparam logic [7:0]  ClickThree       = 8'd3;

endpackage

>>> design/button_click_event_detector_top.sv
// Top level of the button click event detector: debounce, hold and click chaining.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_now_ms, req_pressed
//   rsp      out        rsp_valid / rsp_ready  rsp_fsm_state, rsp_event_code,
//                                              rsp_clicks, rsp_held_ms
//   csr      in         csr_we (no wait)       csr_index, csr_wdata
//
// Every accepted item gives exactly one result item, in the cycle after it is accepted.
// An item is accepted in every cycle while the result register is empty or being taken,
// so the sustained rate is one item per clock; each result is held in the single result register.
// The state update is one level of 32-bit subtract and compare against the stamps.
// A stalled result only holds off the next item; reset clears the state and loads the
// default register values.
module button_click_event_detector_top
   import bced_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [31:0]              req_now_ms,
   input  logic                     req_pressed,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_fsm_state,
   output logic [3:0]               rsp_event_code,
   output logic [7:0]               rsp_clicks,
   output logic [31:0]              rsp_held_ms,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   // Configuration registers.
   logic [15:0] debounce_ff;
   logic [15:0] holddown_ff;
   logic [15:0] long_click_ff;
   logic [15:0] double_click_ff;
   logic        filter_multi_ff;
   logic        enable_ff;

   // Detector state.
   phase_type   phase_ff, phase_in;
   logic [31:0] activity_ff, activity_in;
   logic [31:0] release_ff, release_in;
   logic [31:0] holddown_stamp_ff, holddown_stamp_in;
   logic [31:0] press_length_ff, press_length_in;
   logic [7:0]  tally_ff, tally_in;
   event_type   event_in;

   // Result register.
   logic        rsp_valid_ff;
   phase_type   rsp_phase_ff;
   event_type   rsp_event_ff;
   logic [7:0]  rsp_clicks_ff;
   logic [31:0] rsp_held_ff;

   logic        req_take;
   logic [31:0] since_activity;
   logic [31:0] since_holddown;
   logic [31:0] since_release;
   logic        debounce_done;
   logic        holddown_due;
   logic        chain_click;
   logic        window_done;
   event_type   click_event;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   assign since_activity = req_now_ms - activity_ff;
   assign since_holddown = req_now_ms - holddown_stamp_ff;
   assign since_release  = req_now_ms - release_ff;

   assign debounce_done = since_activity > {16'd0, debounce_ff};
   assign holddown_due  = since_holddown > {16'd0, holddown_ff};
   assign chain_click   = since_release < {16'd0, double_click_ff};
   assign window_done   = (since_activity > {16'd0, double_click_ff}) || !filter_multi_ff;

   always_comb begin
      if (press_length_ff > {16'd0, long_click_ff}) begin
         click_event = EV_LONG;
      end else if (tally_ff == ClickOne) begin
         click_event = EV_CLICK;
      end else if (tally_ff == ClickTwo) begin
         click_event = EV_DOUBLE;
      end else if (tally_ff == ClickThree) begin
         click_event = EV_TRIPLE;
      end else if (tally_ff > ClickThree) begin
         click_event = EV_MULTI;
      end else begin
         click_event = EV_NONE;
      end
   end

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      if (!enable_ff) begin
         phase_in = ST_STANDBY;
      end else if (req_pressed) begin
         unique case (phase_ff)
            ST_STANDBY, ST_POST: phase_in = ST_DEBOUNCE;
            ST_DEBOUNCE: begin
               if (debounce_done) phase_in = ST_ACTIVE;
            end
            ST_ACTIVE: phase_in = ST_ACTIVE;
            default: phase_in = ST_STANDBY;
         endcase
      end else begin
         unique case (phase_ff)
            ST_ACTIVE: phase_in = ST_POST;
            ST_POST: begin
               if (window_done) phase_in = ST_STANDBY;
            end
            default: phase_in = ST_STANDBY;
         endcase
      end
   end

   // Events, stamps and counters.
   always_comb begin
      event_in          = EV_NONE;
      activity_in       = activity_ff;
      release_in        = release_ff;
      holddown_stamp_in = holddown_stamp_ff;
      press_length_in   = press_length_ff;
      tally_in          = tally_ff;
      if (enable_ff) begin
         if (req_pressed) begin
            unique case (phase_ff)
               ST_STANDBY, ST_POST: activity_in = req_now_ms;
               ST_DEBOUNCE: begin
                  if (debounce_done) begin
                     activity_in       = req_now_ms;
                     holddown_stamp_in = req_now_ms;
                     event_in          = EV_DOWN;
                  end
               end
               default: begin
                  press_length_in = since_activity;
                  if (holddown_due) begin
                     holddown_stamp_in = req_now_ms;
                     event_in          = EV_HOLD;
                  end
               end
            endcase
         end else begin
            unique case (phase_ff)
               ST_ACTIVE: begin
                  press_length_in = since_activity;
                  event_in        = EV_UP;
                  if (!chain_click) begin
                     tally_in = ClickOne;
                  end else if (tally_ff != ClickMax) begin
                     tally_in = tally_ff + 8'd1;
                  end
                  release_in        = req_now_ms;
                  activity_in       = req_now_ms;
                  holddown_stamp_in = req_now_ms;
               end
               ST_POST: begin
                  if (window_done) begin
                     event_in    = click_event;
                     activity_in = req_now_ms;
                  end
               end
               default: event_in = EV_NONE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= DebounceReset;
         holddown_ff     <= HolddownReset;
         long_click_ff   <= LongClickReset;
         double_click_ff <= DoubleClickReset;
         filter_multi_ff <= 1'b1;
         enable_ff       <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE:     debounce_ff     <= csr_wdata;
            CSR_HOLDDOWN:     holddown_ff     <= csr_wdata;
            CSR_LONG_CLICK:   long_click_ff   <= csr_wdata;
            CSR_DOUBLE_CLICK: double_click_ff <= csr_wdata;
            CSR_FILTER_MULTI: filter_multi_ff <= csr_wdata[0];
            CSR_ENABLE:       enable_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= ST_STANDBY;
         activity_ff       <= '0;
         release_ff        <= '0;
         holddown_stamp_ff <= '0;
         press_length_ff   <= '0;
         tally_ff          <= '0;
      end else if (req_take) begin
         phase_ff          <= phase_in;
         activity_ff       <= activity_in;
         release_ff        <= release_in;
         holddown_stamp_ff <= holddown_stamp_in;
         press_length_ff   <= press_length_in;
         tally_ff          <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_phase_ff  <= phase_in;
         rsp_event_ff  <= event_in;
         rsp_clicks_ff <= tally_in;
         rsp_held_ff   <= press_length_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fsm_state  = rsp_phase_ff;
   assign rsp_event_code = rsp_event_ff;
   assign rsp_clicks     = rsp_clicks_ff;
   assign rsp_held_ms    = rsp_held_ff;

   // A down event always enters the active state.
   a_down_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_event_ff == EV_DOWN |-> rsp_phase_ff == ST_ACTIVE)
      else $error("down event outside active state");

   // A release from active leaves a nonzero click count in post active.
   a_up_post: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_event_ff == EV_UP |-> rsp_phase_ff == ST_POST && rsp_clicks_ff != 8'd0)
      else $error("up event with wrong state or zero clicks");

   // Click decisions return the machine to standby.
   a_click_standby: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_event_ff == EV_CLICK || rsp_event_ff == EV_LONG ||
      rsp_event_ff == EV_DOUBLE || rsp_event_ff == EV_TRIPLE || rsp_event_ff == EV_MULTI)
      |-> rsp_phase_ff == ST_STANDBY)
      else $error("click event without return to standby");

   // An item taken while disabled forces standby with no event.
   a_disabled: assert property (@(posedge clock) disable iff (reset)
      req_take && !enable_ff |=> phase_ff == ST_STANDBY && rsp_event_ff == EV_NONE)
      else $error("disabled detector left standby or raised an event");

   // A new item is held off only by a result that is waiting.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a waiting result");

endmodule
